### rtl/crcfr_pkg.sv
// shared types, constants and codes for the crc16 frame receiver
// no dependencies

package crcfr_pkg;

  localparam int FRAME_LEN     = 12;
  localparam int TAIL_POS      = 11;
  localparam int BYTE_W        = 8;
  localparam int FILL_W        = 4;
  localparam int CRC_BYTES     = 8;
  localparam int STEP_W        = 3;
  localparam int TRAVEL_DIGITS = 5;
  localparam int TRAVEL_W      = 22;
  localparam int KIND_W        = 2;
  localparam int CFG_IDX_W     = 3;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [7:0] HEADER_RST  = 8'd170;
  localparam logic [7:0] TRAILER_RST = 8'd85;
  localparam logic [7:0] OP_CW_RST   = 8'd1;
  localparam logic [7:0] OP_CCW_RST  = 8'd2;
  localparam logic [7:0] OP_CYC_RST  = 8'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HEADER  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRAILER = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OP_CW   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OP_CCW  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OP_CYC  = 3'd4;

  // command kinds
  localparam logic [KIND_W-1:0] KIND_UNKNOWN = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CW      = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CCW     = 2'd2;
  localparam logic [KIND_W-1:0] KIND_CYCLE   = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN,
    ST_DECIDE
  } state_t;

  typedef struct packed {
    logic load;
    logic crc_step;
    logic trav_step;
  } scan_ctl_t;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [BYTE_W-1:0]   motor;
    logic [TRAVEL_W-1:0] travel;
    logic [BYTE_W-1:0]   cycles;
  } ack_info_t;

endpackage

### rtl/crc16_frame_receiver_echo_core.sv
// input: a byte that does not complete the 12-byte window is taken while the fsm is idle
// a byte that completes it holds the input through load, 8 crc byte steps and decide,
// which on a match waits for a free ack shifter and loads it; the ack then goes out 1 byte/cycle while out_stall is low
// the byte-serial crc pass over frame bytes 1 to 8 sets the per-window cost
// reset: config registers return to defaults, window empty, no ack pending
// top level: window, config registers, control fsm; depends on crcfr_pkg and the units

module crc16_frame_receiver_echo_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [7:0]                          in_rx_byte,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [7:0]                          out_ack_byte,
  output logic                                out_last_byte,
  output logic [1:0]                          out_command_kind,
  output logic [7:0]                          out_motor_select,
  output logic [21:0]                         out_travel,
  output logic [7:0]                          out_cycle_count,
  input  logic                                cfg_we,
  input  logic [crcfr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [7:0]                          cfg_wdata
);
  import crcfr_pkg::*;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [7:0]        win_r [FRAME_LEN];

  logic [7:0] header_r, trailer_r, op_cw_r, op_ccw_r, op_cyc_r;

  scan_ctl_t  ctl;
  ack_info_t  info;
  logic       in_take, slide, ack_load, match, tx_free;
  logic [15:0]                crc;
  logic [TRAVEL_W-1:0]        trav;
  logic [CRC_BYTES*8-1:0]     crc_bytes;
  logic [TRAVEL_DIGITS*8-1:0] digit_bytes;
  logic [FRAME_LEN*8-1:0]     frame_bytes;

  assign in_take = in_valid && !in_stall;

  always_comb begin
    for (int k = 0; k < CRC_BYTES; k++) begin
      crc_bytes[k*8 +: 8] = win_r[k+1];
    end
    for (int k = 0; k < TRAVEL_DIGITS; k++) begin
      digit_bytes[k*8 +: 8] = win_r[k+3];
    end
    for (int k = 0; k < FRAME_LEN; k++) begin
      frame_bytes[k*8 +: 8] = win_r[k];
    end
  end

  crcfr_crc_unit u_crc (
    .clk      (clk),
    .ctl      (ctl),
    .bytes_in (crc_bytes),
    .crc      (crc)
  );

  crcfr_travel_acc u_trav (
    .clk       (clk),
    .ctl       (ctl),
    .digits_in (digit_bytes),
    .travel    (trav)
  );

  // the echo carries all twelve frame bytes unchanged, so its crc is bytes 9 and 10
  crcfr_ack_tx u_tx (
    .clk              (clk),
    .rst_n            (rst_n),
    .load             (ack_load),
    .frame_in         (frame_bytes),
    .info_in          (info),
    .free             (tx_free),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_ack_byte     (out_ack_byte),
    .out_last_byte    (out_last_byte),
    .out_command_kind (out_command_kind),
    .out_motor_select (out_motor_select),
    .out_travel       (out_travel),
    .out_cycle_count  (out_cycle_count)
  );

  assign match = (win_r[0] == header_r) && (win_r[TAIL_POS] == trailer_r)
              && (crc == {win_r[9], win_r[10]});

  // first matching opcode wins
  always_comb begin
    info.kind   = KIND_UNKNOWN;
    info.motor  = win_r[2];
    info.travel = '0;
    info.cycles = '0;
    priority if (win_r[1] == op_cw_r) begin
      info.kind = KIND_CW;
    end else if (win_r[1] == op_ccw_r) begin
      info.kind = KIND_CCW;
    end else if (win_r[1] == op_cyc_r) begin
      info.kind = KIND_CYCLE;
    end else begin
      info.kind = KIND_UNKNOWN;
    end
    if (info.kind != KIND_UNKNOWN) begin
      info.travel = trav;
    end
    if (info.kind == KIND_CYCLE) begin
      info.cycles = win_r[8];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && fill_r == FILL_W'(FRAME_LEN - 1)) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (step_r == STEP_W'(CRC_BYTES - 1)) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (!match || tx_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall      = 1'b1;
    ctl.load      = 1'b0;
    ctl.crc_step  = 1'b0;
    ctl.trav_step = 1'b0;
    slide         = 1'b0;
    ack_load      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
      end
      ST_LOAD: begin
        ctl.load = 1'b1;
      end
      ST_SCAN: begin
        ctl.crc_step  = 1'b1;
        ctl.trav_step = (step_r < STEP_W'(TRAVEL_DIGITS));
      end
      ST_DECIDE: begin
        slide    = !match;
        ack_load = match && tx_free;
      end
      default: in_stall = 1'b1;
    endcase
  end

  always_comb begin
    step_nxt = '0;
    if (state_r == ST_SCAN) begin
      step_nxt = step_r + 1'b1;
    end
    fill_nxt = fill_r;
    if (in_take) begin
      fill_nxt = fill_r + 1'b1;
    end else if (slide) begin
      fill_nxt = FILL_W'(TAIL_POS);
    end else if (ack_load) begin
      fill_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      step_r    <= '0;
      fill_r    <= '0;
      header_r  <= HEADER_RST;
      trailer_r <= TRAILER_RST;
      op_cw_r   <= OP_CW_RST;
      op_ccw_r  <= OP_CCW_RST;
      op_cyc_r  <= OP_CYC_RST;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      fill_r  <= fill_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_HEADER:  header_r  <= cfg_wdata;
          REG_TRAILER: trailer_r <= cfg_wdata;
          REG_OP_CW:   op_cw_r   <= cfg_wdata;
          REG_OP_CCW:  op_ccw_r  <= cfg_wdata;
          REG_OP_CYC:  op_cyc_r  <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // window bytes past the fill count are always written before they are read
  always_ff @(posedge clk) begin
    if (in_take) begin
      win_r[fill_r] <= in_rx_byte;
    end else if (slide) begin
      for (int k = 0; k < TAIL_POS; k++) begin
        win_r[k] <= win_r[k+1];
      end
    end
  end

  // a full window holds twelve bytes while it is checked
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(FRAME_LEN))
    else $error("fill count beyond window");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    ack_load |-> !out_valid)
    else $error("ack loaded while previous ack pending");

  a_slide_fill: assert property (@(posedge clk) disable iff (!rst_n)
    slide |=> (fill_r == FILL_W'(TAIL_POS)) && (state_r == ST_IDLE))
    else $error("slide did not leave eleven bytes");

  a_last_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_last_byte) |=> !out_valid)
    else $error("ack continued after last byte");

endmodule

### rtl/crcfr_crc_unit.sv
// byte-serial modbus crc16 over frame bytes 1 to 8, one byte per cycle
// depends on crcfr_pkg

module crcfr_crc_unit (
  input  logic                                clk,
  input  crcfr_pkg::scan_ctl_t                ctl,
  input  logic [crcfr_pkg::CRC_BYTES*8-1:0]   bytes_in,
  output logic [15:0]                         crc
);
  import crcfr_pkg::*;

  logic [15:0]            crc_r, crc_nxt;
  logic [CRC_BYTES*8-1:0] sh_r, sh_nxt;

  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] v;
    v = c ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
    end
    return v;
  endfunction

  always_comb begin
    crc_nxt = crc_r;
    sh_nxt  = sh_r;
    if (ctl.load) begin
      crc_nxt = CRC_INIT;
      sh_nxt  = bytes_in;
    end else if (ctl.crc_step) begin
      crc_nxt = crc_byte(crc_r, sh_r[7:0]);
      sh_nxt  = sh_r >> 8;
    end
  end

  always_ff @(posedge clk) begin
    crc_r <= crc_nxt;
    sh_r  <= sh_nxt;
  end

  assign crc = crc_r;

endmodule

### rtl/crcfr_travel_acc.sv
// decimal travel from five digit bytes, horner form, one digit per cycle
// depends on crcfr_pkg

module crcfr_travel_acc (
  input  logic                                      clk,
  input  crcfr_pkg::scan_ctl_t                      ctl,
  input  logic [crcfr_pkg::TRAVEL_DIGITS*8-1:0]     digits_in,
  output logic [crcfr_pkg::TRAVEL_W-1:0]            travel
);
  import crcfr_pkg::*;

  logic [TRAVEL_W-1:0]        acc_r, acc_nxt;
  logic [TRAVEL_DIGITS*8-1:0] sh_r, sh_nxt;

  // most significant digit sits in the top byte
  always_comb begin
    acc_nxt = acc_r;
    sh_nxt  = sh_r;
    if (ctl.load) begin
      acc_nxt = '0;
      sh_nxt  = digits_in;
    end else if (ctl.trav_step) begin
      acc_nxt = (acc_r << 3) + (acc_r << 1)
              + TRAVEL_W'(sh_r[TRAVEL_DIGITS*8-1 -: 8]);
      sh_nxt  = sh_r << 8;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    sh_r  <= sh_nxt;
  end

  assign travel = acc_r;

endmodule

### rtl/crcfr_ack_tx.sv
// acknowledgement shifter: twelve bytes out, one per request, with decoded fields
// depends on crcfr_pkg

module crcfr_ack_tx (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 load,
  input  logic [crcfr_pkg::FRAME_LEN*8-1:0]    frame_in,
  input  crcfr_pkg::ack_info_t                 info_in,
  output logic                                 free,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [7:0]                           out_ack_byte,
  output logic                                 out_last_byte,
  output logic [1:0]                           out_command_kind,
  output logic [7:0]                           out_motor_select,
  output logic [21:0]                          out_travel,
  output logic [7:0]                           out_cycle_count
);
  import crcfr_pkg::*;

  logic [FRAME_LEN*8-1:0] sh_r, sh_nxt;
  ack_info_t              info_r, info_nxt;
  logic [FILL_W-1:0]      cnt_r, cnt_nxt;
  logic                   take;

  assign out_valid = (cnt_r != '0);
  assign take      = out_valid && !out_stall;
  assign free      = (cnt_r == '0);

  always_comb begin
    sh_nxt   = sh_r;
    info_nxt = info_r;
    cnt_nxt  = cnt_r;
    if (load) begin
      sh_nxt   = frame_in;
      info_nxt = info_in;
      cnt_nxt  = FILL_W'(FRAME_LEN);
    end else if (take) begin
      sh_nxt  = sh_r >> 8;
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r   <= sh_nxt;
    info_r <= info_nxt;
  end

  assign out_ack_byte     = sh_r[7:0];
  assign out_last_byte    = (cnt_r == FILL_W'(1));
  assign out_command_kind = info_r.kind;
  assign out_motor_select = info_r.motor;
  assign out_travel       = info_r.travel;
  assign out_cycle_count  = info_r.cycles;

endmodule
